@@ rtl/tbse_pkg.sv @@
// Shared types, codes and trit helper functions for the ternary block signature encoder.
`default_nettype none

package tbse_pkg;

  typedef logic [1:0] trit_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HGRAD  = 2'd1,
    KIND_VGRAD  = 2'd2,
    KIND_HTRANS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_MID   = 2'd1,
    PH_LAST  = 2'd2
  } phase_t;

  localparam trit_t TRIT_NEG  = 2'd0;
  localparam trit_t TRIT_ZERO = 2'd1;
  localparam trit_t TRIT_POS  = 2'd2;

  localparam logic [4:0] CODE_FLAT = 5'd13;

  localparam logic [7:0] HIGH_THRESHOLD_RESET = 8'd170;
  localparam logic [7:0] LOW_THRESHOLD_RESET  = 8'd85;

  localparam logic REG_HIGH_THRESHOLD = 1'b0;
  localparam logic REG_LOW_THRESHOLD  = 1'b1;

  localparam int NUM_SLOTS = 4;

  typedef struct packed {
    logic [7:0] high;
    logic [7:0] low;
  } thresh_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] row;
    logic [3:0] blk;
    logic [4:0] code;
  } result_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]          mask;
    result_t [NUM_SLOTS-1:0]       res;
  } group_t;

  function automatic trit_t quantize(input logic [7:0] pix, input thresh_t thr);
    trit_t t;
    if (pix > thr.high) begin
      t = TRIT_POS;
    end else if (pix < thr.low) begin
      t = TRIT_NEG;
    end else begin
      t = TRIT_ZERO;
    end
    return t;
  endfunction

  // Clamped difference b - a of two coded trits, coded the same way.
  function automatic trit_t cdiff(input trit_t a, input trit_t b);
    trit_t t;
    if (b > a) begin
      t = TRIT_POS;
    end else if (b < a) begin
      t = TRIT_NEG;
    end else begin
      t = TRIT_ZERO;
    end
    return t;
  endfunction

  function automatic logic [4:0] code3(input trit_t a, input trit_t b, input trit_t c);
    logic [4:0] sum;
    sum = 5'(a) * 5'd9 + 5'(b) * 5'd3 + 5'(c);
    return sum;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tbse_regs.sv @@
// Configuration register file with an APB-style access port for the two thresholds.
`default_nettype none

module tbse_regs (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output tbse_pkg::thresh_t    thr
);
  import tbse_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.high <= HIGH_THRESHOLD_RESET;
      thr.low  <= LOW_THRESHOLD_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_HIGH_THRESHOLD: thr.high <= pwdata[7:0];
        REG_LOW_THRESHOLD:  thr.low  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HIGH_THRESHOLD: prdata = {24'd0, thr.high};
      REG_LOW_THRESHOLD:  prdata = {24'd0, thr.low};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tbse_encode.sv @@
// Pixel quantizer, raster position counters, row store and result group builder.
`default_nettype none

module tbse_encode #(
  parameter int IMAGE_WIDTH  = 28,
  parameter int IMAGE_HEIGHT = 28
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        pixel,
  input  wire tbse_pkg::thresh_t thr,
  output logic                   grp_valid,
  output tbse_pkg::group_t       grp,
  input  wire logic              grp_take
);
  import tbse_pkg::*;

  localparam int NBLK = IMAGE_WIDTH / 3;
  localparam int XW   = $clog2(IMAGE_WIDTH);
  localparam int YW   = $clog2(IMAGE_HEIGHT);
  localparam int BW   = $clog2(NBLK + 1);

  logic [XW-1:0] col;
  logic [XW-1:0] col_next;
  logic [YW-1:0] row_cnt;
  logic [YW-1:0] row_cnt_next;
  logic [BW-1:0] blk_cnt;
  logic [BW-1:0] blk_cnt_next;
  phase_t        phase;
  phase_t        phase_next;

  trit_t         row_mem [IMAGE_WIDTH];
  trit_t         above;

  logic [7:0]    recent;
  logic [7:0]    recent_next;
  logic [5:0]    recent_vert;
  logic [5:0]    recent_vert_next;
  logic [5:0]    prev_block;

  logic          accept;
  trit_t         e;
  logic          last_col;
  logic          last_row;
  logic          in_range;
  logic          first_blk;
  logic [31:0]   row_wide;
  logic [31:0]   row_up_wide;
  logic [31:0]   blk_wide;
  logic [31:0]   blk_left_wide;
  logic [4:0]    hcode;
  logic [4:0]    pcode;
  logic [4:0]    tcode;
  logic [4:0]    vcode;
  logic [4:0]    ecode;
  group_t        grp_new;

  assign in_stall = grp_valid && !grp_take;
  assign accept   = in_valid && !in_stall;

  assign e         = quantize(pixel, thr);
  assign last_col  = (col == XW'(IMAGE_WIDTH - 1));
  assign last_row  = (row_cnt == YW'(IMAGE_HEIGHT - 1));
  assign in_range  = (32'(blk_cnt) < NBLK);
  assign first_blk = (blk_cnt == '0);

  assign recent_next = {recent[5:0], e};
  assign recent_vert_next = (row_cnt != '0) ? {recent_vert[3:0], cdiff(above, e)}
                                            : recent_vert;

  always_comb begin
    col_next     = last_col ? '0 : col + XW'(1);
    row_cnt_next = row_cnt;
    if (last_col) begin
      row_cnt_next = last_row ? '0 : row_cnt + YW'(1);
    end
    blk_cnt_next = blk_cnt;
    phase_next   = phase;
    if (last_col) begin
      blk_cnt_next = '0;
      phase_next   = PH_FIRST;
    end else begin
      case (phase)
        PH_FIRST: phase_next = PH_MID;
        PH_MID:   phase_next = PH_LAST;
        PH_LAST: begin
          phase_next   = PH_FIRST;
          blk_cnt_next = blk_cnt + BW'(1);
        end
        default:  phase_next = PH_FIRST;
      endcase
    end
  end

  assign row_wide      = 32'(row_cnt);
  assign row_up_wide   = 32'(row_cnt - YW'(1));
  assign blk_wide      = 32'(blk_cnt);
  assign blk_left_wide = 32'(blk_cnt - BW'(1));

  assign hcode = code3(cdiff(recent_next[7:6], recent_next[5:4]),
                       cdiff(recent_next[5:4], recent_next[3:2]),
                       cdiff(recent_next[3:2], recent_next[1:0]));
  assign pcode = code3(recent_next[5:4], recent_next[3:2], recent_next[1:0]);
  assign tcode = code3(cdiff(prev_block[5:4], recent_next[5:4]),
                       cdiff(prev_block[3:2], recent_next[3:2]),
                       cdiff(prev_block[1:0], recent_next[1:0]));
  assign vcode = code3(recent_vert_next[5:4], recent_vert_next[3:2], recent_vert_next[1:0]);
  assign ecode = code3(cdiff(recent_next[5:4], recent_next[3:2]),
                       cdiff(recent_next[3:2], recent_next[1:0]), TRIT_ZERO);

  always_comb begin
    grp_new = '0;
    case (phase)
      PH_FIRST: begin
        grp_new.mask[0]     = !first_blk;
        grp_new.res[0].kind = KIND_HGRAD;
        grp_new.res[0].blk  = blk_left_wide[3:0];
        grp_new.res[0].code = hcode;
      end
      PH_MID: begin
        grp_new.mask[0]     = in_range && last_row;
        grp_new.res[0].kind = KIND_VGRAD;
        grp_new.res[0].blk  = blk_wide[3:0];
        grp_new.res[0].code = CODE_FLAT;
      end
      PH_LAST: begin
        grp_new.mask[0]     = in_range;
        grp_new.res[0].kind = KIND_PIXEL;
        grp_new.res[0].blk  = blk_wide[3:0];
        grp_new.res[0].code = pcode;
        grp_new.mask[1]     = in_range && !first_blk;
        grp_new.mask[2]     = in_range && (row_cnt != '0);
        grp_new.mask[3]     = in_range && last_col;
      end
      default: ;
    endcase
    grp_new.res[0].row  = row_wide[4:0];
    grp_new.res[1].kind = KIND_HTRANS;
    grp_new.res[1].row  = row_wide[4:0];
    grp_new.res[1].blk  = blk_left_wide[3:0];
    grp_new.res[1].code = tcode;
    grp_new.res[2].kind = KIND_VGRAD;
    grp_new.res[2].row  = row_up_wide[4:0];
    grp_new.res[2].blk  = blk_wide[3:0];
    grp_new.res[2].code = vcode;
    grp_new.res[3].kind = KIND_HGRAD;
    grp_new.res[3].row  = row_wide[4:0];
    grp_new.res[3].blk  = blk_wide[3:0];
    grp_new.res[3].code = ecode;
  end

  // The entry for the next column is fetched as the current one is written.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[col] <= e;
      above        <= row_mem[col_next];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp <= grp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row_cnt     <= '0;
      blk_cnt     <= '0;
      phase       <= PH_FIRST;
      recent      <= '0;
      recent_vert <= '0;
      prev_block  <= '0;
      grp_valid   <= 1'b0;
    end else begin
      if (accept && (grp_new.mask != '0)) begin
        grp_valid <= 1'b1;
      end else if (grp_take) begin
        grp_valid <= 1'b0;
      end
      if (accept) begin
        col         <= col_next;
        row_cnt     <= row_cnt_next;
        blk_cnt     <= blk_cnt_next;
        phase       <= phase_next;
        recent      <= recent_next;
        recent_vert <= recent_vert_next;
        if (phase == PH_LAST && in_range) begin
          prev_block <= recent_next[5:0];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_position_consistent: assert property (@(posedge clk) disable iff (rst)
    32'(col) == 32'(blk_cnt) * 3 + 32'(phase))
    else $error("column counter disagrees with block and phase counters");

  a_column_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && last_col |=> (col == '0) && (phase == PH_FIRST) && (blk_cnt == '0))
    else $error("raster position did not wrap at the end of a row");

  a_group_held: assert property (@(posedge clk) disable iff (rst)
    grp_valid && !grp_take |=> grp_valid && $stable(grp))
    else $error("pending result group was lost or changed");
`endif

endmodule

`default_nettype wire

@@ rtl/tbse_serial.sv @@
// Output stage that sends the results of one pixel group one per cycle while out_stall is low.
`default_nettype none

module tbse_serial (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             grp_valid,
  input  wire tbse_pkg::group_t grp,
  output logic                  grp_take,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output tbse_pkg::result_t     res,
  output logic                  last
);
  import tbse_pkg::*;

  logic [NUM_SLOTS-1:0]    pend;
  logic [NUM_SLOTS-1:0]    pend_next;
  logic [NUM_SLOTS-1:0]    low_bit;
  result_t [NUM_SLOTS-1:0] held;
  logic                    out_fire;

  assign out_valid = (pend != '0);
  assign low_bit   = pend & (~pend + NUM_SLOTS'(1));
  assign last      = ((pend & (pend - NUM_SLOTS'(1))) == '0);
  assign out_fire  = out_valid && !out_stall;
  assign pend_next = out_fire ? (pend & ~low_bit) : pend;
  assign grp_take  = grp_valid && (pend_next == '0);

  always_comb begin
    res = held[0];
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        res = held[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take) begin
      held <= grp.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (grp_take) begin
      pend <= grp.mask;
    end else begin
      pend <= pend_next;
    end
  end

`ifndef SYNTHESIS
  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    out_fire && !last |=> out_valid && $stable(held))
    else $error("result group ended before its last result");

  a_take_when_done: assert property (@(posedge clk) disable iff (rst)
    grp_take |-> !out_valid || (out_fire && last))
    else $error("new group taken while results of the current one remain");
`endif

endmodule

`default_nettype wire

@@ rtl/ternary_block_signature_encoder_core.sv @@
// Top level of the ternary block signature encoder: pixel input, code output, register port.
`default_nettype none

// Pixels enter in raster order; each pixel is quantized to a trit with the two threshold
// registers and gives zero to four codes (pixel block, horizontal gradient, vertical
// gradient, horizontal transition), sent one per cycle while out_stall is low, with last
// marking the final code of a pixel. A pixel is registered into the encoder's group
// register when accepted, and its group then moves to the output stage's held register,
// from which its first code is sent. The codes of a pixel take the single output port in
// turn, and a pixel with no codes is still accepted. A row inside a 28-pixel-wide image
// gives 35 codes. The output stage holds one group while the next pixel is encoded into a
// second group register, so in_stall only rises when both are full. The row store keeps
// one trit per column and needs no clearing after reset: row 0 writes every entry before
// any read is used. Threshold registers sit at byte addresses 0 (high) and 4 (low) and
// should only be written while no pixel is in flight.
module ternary_block_signature_encoder_core #(
  parameter int IMAGE_WIDTH  = 28,
  parameter int IMAGE_HEIGHT = 28
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   pixel,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        kind,
  output logic [4:0]        row,
  output logic [3:0]        block,
  output logic [4:0]        code,
  output logic              last
);
  import tbse_pkg::*;

  thresh_t thr;
  group_t  grp;
  logic    grp_valid;
  logic    grp_take;
  result_t res;

  tbse_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  tbse_encode #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_encode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .thr       (thr),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_take  (grp_take)
  );

  tbse_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_take  (grp_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .last      (last)
  );

  assign kind  = res.kind;
  assign row   = res.row;
  assign block = res.blk;
  assign code  = res.code;

endmodule

`default_nettype wire
